// ----- rtl/core/rpaa_pkg.sv -----
`timescale 1ns / 1ps

package rpaa_pkg;

    // Cycles from an accepted item to the registered unit axis.
    localparam int NORM_LAT = 68;
    // Register stages of the quaternion product and saturation.
    localparam int ROT_LAT = 9;

    localparam int ATAN_ENTRIES = 30;
    localparam logic signed [33:0] CORDIC_START = 34'sh026DD3B6A;
    localparam logic signed [33:0] ONE_Q30 = 34'sh040000000;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    typedef logic signed [31:0] coord_t;

endpackage

// ----- rtl/core/rotate_point_axis_angle_core.sv -----
`timescale 1ns / 1ps

// Rotates a 3D point about an arbitrary axis by an angle, through the unit
// quaternion q = (cos h, u sin h) and the product q p q*.
// The input channel (s_) carries one item per handshake: the point, the axis
// (any length, Q16.16) and the angle as a 16-bit fraction of a full turn.
// The result channel (m_) returns the rotated point in Q16.16, saturated, and
// a clipped flag in m_tuser when any coordinate had to saturate.
// Every item yields exactly one result, in order.
// An accepted item passes through the axis normalization (squares, sum, shift,
// a 32-stage square root and a 31-stage divider) and then through the
// quaternion products and saturation to m_tvalid. The half-angle
// CORDIC runs alongside the normalization and is aligned to it.
// Throughput is one item per cycle. The whole pipeline advances together;
// when the receiver holds m_tready low while a result is shown, every stage
// holds and s_tready drops, so nothing is lost or repeated. Empty stages
// still flow while the output register is empty or being taken.
// Synchronous reset clears all valid bits; the data path is not reset.
module rotate_point_axis_angle_core import rpaa_pkg::*; #(
    parameter int TRIG_STAGES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // point_x, point_y, point_z, axis_x, axis_y, axis_z, turn_angle (low bit up)
    input  logic [207:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rotated_x, rotated_y, rotated_z (low bit up)
    output logic [95:0]  m_tdata,
    // clipped
    output logic         m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready
);

    localparam int ANG_DLY = NORM_LAT - TRIG_STAGES - 2;

    // One enable for all stages: move whenever the output register is free.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    coord_t pt_in [3];
    coord_t ax_in [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            pt_in[c] = s_tdata[32*c +: 32];
            ax_in[c] = s_tdata[96 + 32*c +: 32];
        end
    end

    logic   nrm_valid;
    coord_t unit_v [3];

    rpaa_axis_norm u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .axis_in  (ax_in),
        .out_valid(nrm_valid),
        .unit_out (unit_v)
    );

    // The angle waits so that the CORDIC result lands with the unit axis.
    logic [15:0] ang_dly_reg [ANG_DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_dly_reg[0] <= s_tdata[207:192];
            for (int i = 1; i < ANG_DLY; i++) begin
                ang_dly_reg[i] <= ang_dly_reg[i-1];
            end
        end
    end

    coord_t cos_h, sin_h;

    rpaa_cordic #(
        .STAGES(TRIG_STAGES)
    ) u_cordic (
        .aclk (aclk),
        .en   (en),
        .angle(ang_dly_reg[ANG_DLY-1]),
        .cos_h(cos_h),
        .sin_h(sin_h)
    );

    // The point travels alongside the normalization.
    coord_t pt_dly_reg [NORM_LAT][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            pt_dly_reg[0] <= pt_in;
            for (int i = 1; i < NORM_LAT; i++) begin
                pt_dly_reg[i] <= pt_dly_reg[i-1];
            end
        end
    end

    coord_t rot [3];

    rpaa_rotate u_rotate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (nrm_valid),
        .unit_in  (unit_v),
        .cos_h    (cos_h),
        .sin_h    (sin_h),
        .point    (pt_dly_reg[NORM_LAT-1]),
        .out_valid(m_tvalid),
        .rot      (rot),
        .clipped  (m_tuser)
    );

    assign m_tdata = {rot[2], rot[1], rot[0]};

endmodule

// ----- rtl/core/rpaa_axis_norm.sv -----
`timescale 1ns / 1ps

module rpaa_axis_norm import rpaa_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  coord_t axis_in [3],
    output logic   out_valid,
    output coord_t unit_out [3]
);

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [4:0]       k;
        logic             zero;
    } side_t;

    logic [NORM_LAT-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NORM_LAT-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NORM_LAT-1];

    // Squares of the component magnitudes.
    side_t       s1_side_reg;
    logic [63:0] sq_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                logic [31:0] m;
                m = axis_in[c][31] ? 32'(-axis_in[c]) : 32'(axis_in[c]);
                s1_side_reg.mag[c] <= m;
                s1_side_reg.neg[c] <= axis_in[c][31];
                sq_reg[c] <= 64'(m) * 64'(m);
            end
            s1_side_reg.k    <= '0;
            s1_side_reg.zero <= 1'b0;
        end
    end

    // Squared length.
    side_t       s2_side_reg;
    logic [63:0] len_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_side_reg <= s1_side_reg;
            len_reg     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // Even normalizing shift so that bit 62 or 63 is set.
    logic [5:0] hi_bit;
    logic [4:0] k_shift;

    always_comb begin
        hi_bit = '0;
        for (int b = 0; b < 64; b++) begin
            if (len_reg[b]) begin
                hi_bit = 6'(b);
            end
        end
        k_shift = 5'((6'd63 - hi_bit) >> 1);
    end

    side_t       sq_side_reg [33];
    logic [63:0] sq_n_reg    [33];
    logic [63:0] sq_r_reg    [33];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_t side;
            side      = s2_side_reg;
            side.k    = k_shift;
            side.zero = (len_reg == 64'd0);
            sq_side_reg[0] <= side;
            sq_n_reg[0]    <= len_reg << {k_shift, 1'b0};
            sq_r_reg[0]    <= '0;
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar j = 0; j < 32; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_side_reg[j+1] <= sq_side_reg[j];
                if (sq_n_reg[j] >= sq_r_reg[j] + BIT) begin
                    sq_n_reg[j+1] <= sq_n_reg[j] - (sq_r_reg[j] + BIT);
                    sq_r_reg[j+1] <= (sq_r_reg[j] >> 1) + BIT;
                end else begin
                    sq_n_reg[j+1] <= sq_n_reg[j];
                    sq_r_reg[j+1] <= sq_r_reg[j] >> 1;
                end
            end
        end
    end

    // Division setup: numerator is mag * 2^(30+k) + s/2, divisor is s.
    logic [31:0] dv_s_reg    [32];
    logic [2:0]  dv_neg_reg  [32];
    logic        dv_zero_reg [32];
    logic [31:0] dv_rem_reg  [32][3];
    logic [30:0] dv_low_reg  [32][3];
    logic [30:0] dv_q_reg    [32][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            logic [31:0] s;
            logic [93:0] num;
            s = sq_r_reg[32][31:0];
            dv_s_reg[0]    <= s;
            dv_neg_reg[0]  <= sq_side_reg[32].neg;
            dv_zero_reg[0] <= sq_side_reg[32].zero;
            for (int c = 0; c < 3; c++) begin
                num = (94'(sq_side_reg[32].mag[c]) << (7'd30 + 7'(sq_side_reg[32].k)))
                    + 94'(s >> 1);
                dv_rem_reg[0][c] <= num[62:31];
                dv_low_reg[0][c] <= num[30:0];
                dv_q_reg[0][c]   <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar j = 0; j < 31; j++) begin : g_div
        always_ff @(posedge aclk) begin
            if (en) begin
                logic [32:0] t;
                dv_s_reg[j+1]    <= dv_s_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                for (int c = 0; c < 3; c++) begin
                    t = {dv_rem_reg[j][c], dv_low_reg[j][c][30]};
                    dv_low_reg[j+1][c] <= {dv_low_reg[j][c][29:0], 1'b0};
                    if (t >= {1'b0, dv_s_reg[j]}) begin
                        dv_rem_reg[j+1][c] <= 32'(t - {1'b0, dv_s_reg[j]});
                        dv_q_reg[j+1][c]   <= {dv_q_reg[j][c][29:0], 1'b1};
                    end else begin
                        dv_rem_reg[j+1][c] <= t[31:0];
                        dv_q_reg[j+1][c]   <= {dv_q_reg[j][c][29:0], 1'b0};
                    end
                end
            end
        end
    end

    coord_t unit_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                if (dv_zero_reg[31]) begin
                    unit_reg[c] <= '0;
                end else if (dv_neg_reg[31][c]) begin
                    unit_reg[c] <= -coord_t'({1'b0, dv_q_reg[31][c]});
                end else begin
                    unit_reg[c] <= coord_t'({1'b0, dv_q_reg[31][c]});
                end
            end
        end
    end

    assign unit_out = unit_reg;

endmodule

// ----- rtl/core/rpaa_cordic.sv -----
`timescale 1ns / 1ps

module rpaa_cordic import rpaa_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] angle,
    output coord_t      cos_h,
    output coord_t      sin_h
);

    logic signed [33:0] cx_reg [STAGES+1];
    logic signed [33:0] cy_reg [STAGES+1];
    logic signed [33:0] z_reg  [STAGES+1];
    logic               up_reg [STAGES+1];

    // Half angle; the upper quarter turn is folded onto its residual.
    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0] <= CORDIC_START;
            cy_reg[0] <= '0;
            z_reg[0]  <= 34'({angle[14:0], 15'd0});
            up_reg[0] <= angle[15];
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [33:0] ANG = 34'(ATAN_TURN[i]);
        always_ff @(posedge aclk) begin
            if (en) begin
                up_reg[i+1] <= up_reg[i];
                if (!z_reg[i][33]) begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    z_reg[i+1]  <= z_reg[i] - ANG;
                end else begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    z_reg[i+1]  <= z_reg[i] + ANG;
                end
            end
        end
    end

    function automatic coord_t clamp_q30(input logic signed [33:0] v);
        if (v > ONE_Q30) begin
            return coord_t'(ONE_Q30);
        end else if (v < -ONE_Q30) begin
            return coord_t'(-ONE_Q30);
        end
        return coord_t'(v);
    endfunction

    coord_t cos_reg, sin_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= clamp_q30(up_reg[STAGES] ? -cy_reg[STAGES] : cx_reg[STAGES]);
            sin_reg <= clamp_q30(up_reg[STAGES] ? cx_reg[STAGES] : cy_reg[STAGES]);
        end
    end

    assign cos_h = cos_reg;
    assign sin_h = sin_reg;

endmodule

// ----- rtl/core/rpaa_rotate.sv -----
`timescale 1ns / 1ps

module rpaa_rotate import rpaa_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  coord_t unit_in [3],
    input  coord_t cos_h,
    input  coord_t sin_h,
    input  coord_t point [3],
    output logic   out_valid,
    output coord_t rot [3],
    output logic   clipped
);

    logic [ROT_LAT-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ROT_LAT-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[ROT_LAT-1];

    // Stage 1: axis times sine of the half angle.
    logic signed [63:0] vp_reg [3];
    coord_t             w1_reg;
    coord_t             p1_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                vp_reg[c] <= unit_in[c] * sin_h;
            end
            w1_reg <= cos_h;
            p1_reg <= point;
        end
    end

    // Stage 2: round to Q1.30 and clamp. q(0) is w, q(1..3) the vector part.
    coord_t q2_reg [4];
    coord_t p2_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            logic signed [63:0] rr;
            logic signed [33:0] rv;
            for (int c = 0; c < 3; c++) begin
                rr = vp_reg[c] + 64'sd536870912;
                rv = rr[63:30];
                if (rv > ONE_Q30) begin
                    q2_reg[c+1] <= coord_t'(ONE_Q30);
                end else if (rv < -ONE_Q30) begin
                    q2_reg[c+1] <= coord_t'(-ONE_Q30);
                end else begin
                    q2_reg[c+1] <= coord_t'(rv);
                end
            end
            q2_reg[0] <= w1_reg;
            p2_reg    <= p1_reg;
        end
    end

    // Stage 3: products of q and p.
    logic signed [63:0] mt_reg [12];
    coord_t             q3_reg [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            mt_reg[0]  <= q2_reg[1] * p2_reg[0];
            mt_reg[1]  <= q2_reg[2] * p2_reg[1];
            mt_reg[2]  <= q2_reg[3] * p2_reg[2];
            mt_reg[3]  <= q2_reg[0] * p2_reg[0];
            mt_reg[4]  <= q2_reg[2] * p2_reg[2];
            mt_reg[5]  <= q2_reg[3] * p2_reg[1];
            mt_reg[6]  <= q2_reg[0] * p2_reg[1];
            mt_reg[7]  <= q2_reg[3] * p2_reg[0];
            mt_reg[8]  <= q2_reg[1] * p2_reg[2];
            mt_reg[9]  <= q2_reg[0] * p2_reg[2];
            mt_reg[10] <= q2_reg[1] * p2_reg[1];
            mt_reg[11] <= q2_reg[2] * p2_reg[0];
            q3_reg     <= q2_reg;
        end
    end

    // Stage 4: round each product to Q16.16.
    logic signed [33:0] rt_reg [12];
    coord_t             q4_reg [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            logic signed [63:0] rr;
            for (int i = 0; i < 12; i++) begin
                rr = mt_reg[i] + 64'sd536870912;
                rt_reg[i] <= rr[63:30];
            end
            q4_reg <= q3_reg;
        end
    end

    // Stage 5: t = q * p; t(0) is the scalar part.
    logic signed [35:0] t_reg  [4];
    coord_t             q5_reg [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg[0] <= -(36'(rt_reg[0]) + 36'(rt_reg[1]) + 36'(rt_reg[2]));
            t_reg[1] <= 36'(rt_reg[3]) + 36'(rt_reg[4]) - 36'(rt_reg[5]);
            t_reg[2] <= 36'(rt_reg[6]) + 36'(rt_reg[7]) - 36'(rt_reg[8]);
            t_reg[3] <= 36'(rt_reg[9]) + 36'(rt_reg[10]) - 36'(rt_reg[11]);
            q5_reg   <= q4_reg;
        end
    end

    // Stage 6: products for the vector part of t * conj(q).
    logic signed [67:0] mr_reg [12];

    always_ff @(posedge aclk) begin
        if (en) begin
            mr_reg[0]  <= q5_reg[0] * t_reg[1];
            mr_reg[1]  <= q5_reg[1] * t_reg[0];
            mr_reg[2]  <= q5_reg[3] * t_reg[2];
            mr_reg[3]  <= q5_reg[2] * t_reg[3];
            mr_reg[4]  <= q5_reg[0] * t_reg[2];
            mr_reg[5]  <= q5_reg[2] * t_reg[0];
            mr_reg[6]  <= q5_reg[1] * t_reg[3];
            mr_reg[7]  <= q5_reg[3] * t_reg[1];
            mr_reg[8]  <= q5_reg[0] * t_reg[3];
            mr_reg[9]  <= q5_reg[3] * t_reg[0];
            mr_reg[10] <= q5_reg[2] * t_reg[1];
            mr_reg[11] <= q5_reg[1] * t_reg[2];
        end
    end

    // Stage 7: rounding.
    logic signed [37:0] rr_reg [12];

    always_ff @(posedge aclk) begin
        if (en) begin
            logic signed [67:0] rr;
            for (int i = 0; i < 12; i++) begin
                rr = mr_reg[i] + 68'sd536870912;
                rr_reg[i] <= rr[67:30];
            end
        end
    end

    // Stage 8: w t - tw v - t x v.
    logic signed [39:0] sum_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                sum_reg[c] <= 40'(rr_reg[4*c]) - 40'(rr_reg[4*c+1])
                            - 40'(rr_reg[4*c+2]) + 40'(rr_reg[4*c+3]);
            end
        end
    end

    // Stage 9: saturation; this is the output register.
    coord_t rot_reg [3];
    logic   clip_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            logic any;
            any = 1'b0;
            for (int c = 0; c < 3; c++) begin
                if (sum_reg[c] > 40'sd2147483647) begin
                    rot_reg[c] <= 32'sh7FFFFFFF;
                    any = 1'b1;
                end else if (sum_reg[c] < -40'sd2147483648) begin
                    rot_reg[c] <= 32'sh80000000;
                    any = 1'b1;
                end else begin
                    rot_reg[c] <= coord_t'(sum_reg[c]);
                end
            end
            clip_reg <= any;
        end
    end

    assign rot     = rot_reg;
    assign clipped = clip_reg;

endmodule

// ----- rtl/core/rpaa_checker.sv -----
`timescale 1ns / 1ps

module rpaa_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic [95:0]  m_tdata,
    input logic         m_tuser,
    input logic         m_tvalid,
    input logic         m_tready
);

    // No result survives a reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An empty output register never blocks the input.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // A stalled output stalls the whole pipeline.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");

    // The clipped flag means some coordinate sits at a saturation bound.
    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[31:0] == 32'h7FFFFFFF || m_tdata[31:0] == 32'h80000000 ||
            m_tdata[63:32] == 32'h7FFFFFFF || m_tdata[63:32] == 32'h80000000 ||
            m_tdata[95:64] == 32'h7FFFFFFF || m_tdata[95:64] == 32'h80000000)
        else $error("clipped without a saturated coordinate");

endmodule

bind rotate_point_axis_angle_core rpaa_checker u_rpaa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
);
